// ===== rtl/ppa_pkg.sv =====
// shared widths and constants for the polygon perimeter and area block
`default_nettype none

package ppa_pkg;

  localparam int COORD_W      = 16;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int SQ_W         = 2 * DIFF_W;
  localparam int FRAC_BITS    = 8;
  localparam int ROOT_W       = SQ_W / 2 + FRAC_BITS;
  localparam int CR_W         = 2 * COORD_W + 1;
  localparam int PERIM_W      = 37;
  localparam int AREA_W       = 44;
  localparam int TOTAL_W      = 13;
  localparam int MAX_VERTICES = 4096;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  localparam logic [PERIM_W-1:0] PERIM_MAX = {PERIM_W{1'b1}};
  localparam logic [AREA_W-1:0]  AREA_MAX  = {1'b0, {(AREA_W-1){1'b1}}};
  localparam logic [AREA_W-1:0]  AREA_MIN  = {1'b1, {(AREA_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== rtl/ppa_sqrt.sv =====
// iterative fixed-point square root, one result bit per cycle
`default_nettype none

module ppa_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ppa_pkg::SQ_W-1:0]   radicand,
  output logic                            done,
  output logic [ppa_pkg::ROOT_W-1:0]      root
);

  localparam int SH_W  = 2 * ppa_pkg::ROOT_W;
  localparam int REM_W = ppa_pkg::ROOT_W + 2;
  localparam int IT_W  = $clog2(ppa_pkg::ROOT_W);

  logic [SH_W-1:0]  sh;
  logic [REM_W-1:0] rem;
  logic [IT_W-1:0]  iter;
  logic             busy;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             ge;

  assign rem_sh = {rem, sh[SH_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root, 2'b01});
  assign diff   = rem_sh - trial;
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (iter == IT_W'(ppa_pkg::ROOT_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= SH_W'(radicand) << (2 * ppa_pkg::FRAC_BITS);
      rem  <= '0;
      root <= '0;
      iter <= '0;
    end else if (busy) begin
      sh   <= sh << 2;
      rem  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root <= {root[ppa_pkg::ROOT_W-2:0], ge};
      iter <= iter + IT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/polygon_perimeter_area.sv =====
// top level: vertex sequencer, shared multiplier and running sums
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  vertex  | in_valid in_ready x_coord y_coord last_vertex   | in
//  result  | out_valid out_ready perimeter twice_area        | out
//          | vertex_total overflow                           |
//
// each edge runs through the multiplier states M0 to M4 and the square root (one root
// bit per cycle, 25 bits), then the accumulate; the next vertex is taken only once
// the edge is accumulated. A first vertex that is not also the last is only stored;
// a later last vertex runs its own edge and the closing edge, then hands over the result.
// rst is synchronous and clears the sequencer and the sums.
// in_ready is high only while the sequencer is idle; a result waiting in the
// output register holds the next result back, not the next vertex.
`default_nettype none

module polygon_perimeter_area (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [ppa_pkg::COORD_W-1:0]  x_coord,
  input  wire logic signed [ppa_pkg::COORD_W-1:0]  y_coord,
  input  wire logic                                last_vertex,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [ppa_pkg::PERIM_W-1:0]              perimeter,
  output logic signed [ppa_pkg::AREA_W-1:0]        twice_area,
  output logic [ppa_pkg::TOTAL_W-1:0]              vertex_total,
  output logic                                     overflow
);

  localparam int CW = ppa_pkg::COORD_W;
  localparam int DW = ppa_pkg::DIFF_W;
  localparam int AW = ppa_pkg::AREA_W;
  localparam int PW = ppa_pkg::PERIM_W;
  localparam int RW = ppa_pkg::CR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M0   = 3'd1;
  localparam logic [2:0] S_M1   = 3'd2;
  localparam logic [2:0] S_M2   = 3'd3;
  localparam logic [2:0] S_M3   = 3'd4;
  localparam logic [2:0] S_M4   = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0] state;

  logic signed [CW-1:0] first_x, first_y, prev_x, prev_y;
  logic [ppa_pkg::CNT_W-1:0] count;
  logic [PW-1:0]        perimeter_sum;
  logic signed [AW-1:0] cross_sum;
  logic                 overflowed;
  logic                 closing;
  logic                 last_pend;

  logic signed [CW-1:0] ax, ay, bx, by;
  logic signed [DW-1:0] dx, dy;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [ppa_pkg::SQ_W-1:0] prod;
  logic [ppa_pkg::SQ_W-1:0] sq;
  logic signed [RW-1:0] cr;

  logic sqrt_start;
  logic sqrt_done;
  logic [ppa_pkg::ROOT_W-1:0] root;

  logic [PW:0]   psum;
  logic [AW:0]   csum;

  ppa_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sq),
    .done     (sqrt_done),
    .root     (root)
  );

  assign in_ready   = (state == S_IDLE);
  assign sqrt_start = (state == S_M3);

  // shared multiplier operand select
  always_comb begin
    case (state)
      S_M0:    begin mul_a = dx;            mul_b = dx;            end
      S_M1:    begin mul_a = dy;            mul_b = dy;            end
      S_M2:    begin mul_a = {ax[CW-1], ax}; mul_b = {by[CW-1], by}; end
      S_M3:    begin mul_a = {ay[CW-1], ay}; mul_b = {bx[CW-1], bx}; end
      default: begin mul_a = dx;            mul_b = dy;            end
    endcase
  end

  assign psum = {1'b0, perimeter_sum} + (PW+1)'(root);
  assign csum = {cross_sum[AW-1], cross_sum} + {{(AW+1-RW){cr[RW-1]}}, cr};

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_M1:    sq <= prod;
      S_M2:    sq <= sq + prod;
      S_M3:    cr <= prod[RW-1:0];
      S_M4:    cr <= cr - prod[RW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_x       <= '0;
      first_y       <= '0;
      prev_x        <= '0;
      prev_y        <= '0;
      count         <= '0;
      perimeter_sum <= '0;
      cross_sum     <= '0;
      overflowed    <= 1'b0;
      closing       <= 1'b0;
      last_pend     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_pend <= last_vertex;
            prev_x    <= x_coord;
            prev_y    <= y_coord;
            if (count == '0) begin
              first_x       <= x_coord;
              first_y       <= y_coord;
              perimeter_sum <= '0;
              cross_sum     <= '0;
              overflowed    <= 1'b0;
              count         <= ppa_pkg::CNT_W'(1);
              ax <= x_coord; ay <= y_coord; bx <= x_coord; by <= y_coord;
              dx <= '0;
              dy <= '0;
              closing <= 1'b1;
              state   <= last_vertex ? S_M0 : S_IDLE;
            end else begin
              ax <= prev_x; ay <= prev_y; bx <= x_coord; by <= y_coord;
              dx <= {x_coord[CW-1], x_coord} - {prev_x[CW-1], prev_x};
              dy <= {y_coord[CW-1], y_coord} - {prev_y[CW-1], prev_y};
              if (count >= ppa_pkg::CNT_W'(ppa_pkg::MAX_VERTICES)) begin
                overflowed <= 1'b1;
              end else begin
                count <= count + ppa_pkg::CNT_W'(1);
              end
              closing <= 1'b0;
              state   <= S_M0;
            end
          end
        end
        S_M0: state <= S_M1;
        S_M1: state <= S_M2;
        S_M2: state <= S_M3;
        S_M3: state <= S_M4;
        S_M4: state <= S_WAIT;
        S_WAIT: begin
          if (sqrt_done) begin
            perimeter_sum <= psum[PW] ? ppa_pkg::PERIM_MAX : psum[PW-1:0];
            if (csum[AW] != csum[AW-1]) begin
              cross_sum <= csum[AW] ? ppa_pkg::AREA_MIN : ppa_pkg::AREA_MAX;
            end else begin
              cross_sum <= csum[AW-1:0];
            end
            if (closing) begin
              state <= S_EMIT;
            end else if (last_pend) begin
              // closing edge back to the first vertex
              ax <= prev_x; ay <= prev_y; bx <= first_x; by <= first_y;
              dx <= {first_x[CW-1], first_x} - {prev_x[CW-1], prev_x};
              dy <= {first_y[CW-1], first_y} - {prev_y[CW-1], prev_y};
              closing <= 1'b1;
              state   <= S_M0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            perimeter     <= perimeter_sum;
            twice_area    <= cross_sum;
            vertex_total  <= ppa_pkg::TOTAL_W'(count);
            overflow      <= overflowed;
            count         <= '0;
            perimeter_sum <= '0;
            cross_sum     <= '0;
            overflowed    <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== verif/polygon_perimeter_area_test.sv =====
// self-checking testbench for the streaming polygon perimeter and shoelace area block
`timescale 1ns / 100ps

module polygon_perimeter_area_test;

  localparam int LIMIT_CYCLES = 500_000;
  localparam int TAIL_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 250;
  localparam int C_HI         = 2 ** (ppa_pkg::COORD_W - 1) - 1;
  localparam int C_LO         = -C_HI - 1;
  localparam longint unsigned PERIM_TOP = ppa_pkg::PERIM_MAX;
  localparam longint AREA_HI  = $signed(ppa_pkg::AREA_MAX);
  localparam longint AREA_LO  = $signed(ppa_pkg::AREA_MIN);

  typedef struct {
    logic signed [ppa_pkg::COORD_W-1:0] x;
    logic signed [ppa_pkg::COORD_W-1:0] y;
    logic                               last;
  } vertex_t;

  typedef struct {
    logic [ppa_pkg::PERIM_W-1:0] perimeter;
    logic [ppa_pkg::AREA_W-1:0]  twice_area;
    logic [ppa_pkg::TOTAL_W-1:0] total;
    logic                        ovf;
  } shape_t;

  typedef enum int {SPAN_FULL, SPAN_NEAR, SPAN_CORNER, SPAN_MIXED} span_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ppa_pkg::COORD_W-1:0] x_coord = '0;
  logic signed [ppa_pkg::COORD_W-1:0] y_coord = '0;
  logic last_vertex = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ppa_pkg::PERIM_W-1:0] perimeter;
  logic signed [ppa_pkg::AREA_W-1:0] twice_area;
  logic [ppa_pkg::TOTAL_W-1:0] vertex_total;
  logic overflow;

  polygon_perimeter_area dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .last_vertex  (last_vertex),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .perimeter    (perimeter),
    .twice_area   (twice_area),
    .vertex_total (vertex_total),
    .overflow     (overflow)
  );

  vertex_t vertex_q[$];
  shape_t  shape_q[$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  logic in_took = 1'b0;
  int  errors = 0;
  int  cycle_count = 0;
  int  vertices_taken = 0;
  int  shapes_checked = 0;
  int  ovf_shapes = 0;
  int  clamped_shapes = 0;

  // running polygon state
  int              start_x, start_y, last_x, last_y;
  int              seen_count = 0;
  longint unsigned run_perim = 0;
  longint          run_area = 0;
  logic            run_ovf = 1'b0;
  logic            run_clamped = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  // truncated square root with FRAC_BITS fraction bits
  function automatic longint unsigned edge_length(input longint unsigned sq);
    longint unsigned scaled, root, trial;
    int b;
    scaled = sq << (2 * ppa_pkg::FRAC_BITS);
    root = 0;
    for (b = ppa_pkg::ROOT_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= scaled) root = trial;
    end
    return root;
  endfunction

  task automatic add_edge(input int ax, input int ay, input int bx, input int by);
    longint dx, dy, wedge;
    longint unsigned len;
    dx = longint'(bx) - ax;
    dy = longint'(by) - ay;
    len = edge_length(longint'(dx * dx + dy * dy));
    wedge = longint'(ax) * by - longint'(ay) * bx;
    if (len > PERIM_TOP - run_perim) begin
      run_perim = PERIM_TOP;
      run_clamped = 1'b1;
    end else begin
      run_perim += len;
    end
    run_area += wedge;
    if (run_area > AREA_HI) begin
      run_area = AREA_HI;
      run_clamped = 1'b1;
    end else if (run_area < AREA_LO) begin
      run_area = AREA_LO;
      run_clamped = 1'b1;
    end
  endtask

  task automatic fold_vertex(input vertex_t v);
    shape_t s;
    if (seen_count == 0) begin
      start_x = v.x;
      start_y = v.y;
      run_perim = 0;
      run_area = 0;
      run_ovf = 1'b0;
      run_clamped = 1'b0;
      seen_count = 1;
    end else begin
      add_edge(last_x, last_y, v.x, v.y);
      if (seen_count >= ppa_pkg::MAX_VERTICES) run_ovf = 1'b1;
      else seen_count++;
    end
    last_x = v.x;
    last_y = v.y;
    if (v.last) begin
      add_edge(v.x, v.y, start_x, start_y);
      s.perimeter = run_perim[ppa_pkg::PERIM_W-1:0];
      s.twice_area = run_area[ppa_pkg::AREA_W-1:0];
      s.total = seen_count[ppa_pkg::TOTAL_W-1:0];
      s.ovf = run_ovf;
      shape_q.push_back(s);
      if (run_ovf) ovf_shapes++;
      if (run_clamped) clamped_shapes++;
      seen_count = 0;
      run_perim = 0;
      run_area = 0;
      run_ovf = 1'b0;
    end
  endtask

  // request driver
  always @(negedge clk) begin
    vertex_t v;
    if (!rst) begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!in_valid || in_took) begin
        if (vertex_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          v = vertex_q.pop_front();
          x_coord <= v.x;
          y_coord <= v.y;
          last_vertex <= v.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    shape_t want;
    vertex_t v;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (shape_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result perimeter %0d twice_area %0d total %0d overflow %0b",
                   $time, perimeter, twice_area, vertex_total, overflow);
        end else begin
          want = shape_q.pop_front();
          shapes_checked++;
          if (perimeter !== want.perimeter) begin
            errors++;
            $display("%0t: perimeter expected %0d actual %0d",
                     $time, want.perimeter, perimeter);
          end
          if (twice_area !== want.twice_area) begin
            errors++;
            $display("%0t: twice_area expected %0d actual %0d",
                     $time, $signed(want.twice_area), twice_area);
          end
          if (vertex_total !== want.total) begin
            errors++;
            $display("%0t: vertex_total expected %0d actual %0d",
                     $time, want.total, vertex_total);
          end
          if (overflow !== want.ovf) begin
            errors++;
            $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, overflow);
          end
        end
      end
      if (in_valid && in_ready) begin
        v.x = x_coord;
        v.y = y_coord;
        v.last = last_vertex;
        fold_vertex(v);
        vertices_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, shape_q.size());
      $display("FAIL polygon_perimeter_area");
      $finish;
    end
  end

  task automatic queue_vertex(input int x, input int y, input logic last);
    vertex_t v;
    v.x = 16'(x);
    v.y = 16'(y);
    v.last = last;
    vertex_q.push_back(v);
  endtask

  function automatic int pick_coord(input span_t span);
    case (span)
      SPAN_FULL: return $urandom_range(65535) - 32768;
      SPAN_NEAR: return $urandom_range(40) - 20;
      SPAN_CORNER: begin
        case ($urandom_range(5))
          0: return C_LO;
          1: return C_HI;
          2: return 0;
          3: return -1;
          4: return 1;
          default: return C_LO + 1;
        endcase
      end
      default: return pick_coord(span_t'($urandom_range(2)));
    endcase
  endfunction

  task automatic queue_polygon(input int n, input span_t span);
    int k;
    for (k = 0; k < n; k++) queue_vertex(pick_coord(span), pick_coord(span), k == n - 1);
  endtask

  // walks the corners of the full coordinate square
  task automatic queue_square_loop(input int n, input logic ccw);
    int cx[4], cy[4];
    int k, j;
    cx = '{C_HI, C_HI, C_LO, C_LO};
    cy = '{C_LO, C_HI, C_HI, C_LO};
    for (k = 0; k < n; k++) begin
      j = ccw ? (k % 4) : (3 - k % 4);
      queue_vertex(cx[j], cy[j], k == n - 1);
    end
  endtask

  task automatic queue_random(input int items);
    int added, n, pick;
    added = 0;
    while (added < items) begin
      pick = $urandom_range(99);
      if (pick < 10) n = 1;
      else if (pick < 80) n = $urandom_range(8, 2);
      else n = $urandom_range(40, 9);
      queue_polygon(n, span_t'($urandom_range(3)));
      added += n;
    end
  endtask

  task automatic drain();
    while (vertex_q.size() != 0 || in_valid || shape_q.size() != 0) @(posedge clk);
  endtask

  // sender holds off mid-phase until all results are back
  task automatic run_phase(input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    queue_random(PHASE_ITEMS / 2);
    drain();
    queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
    drain();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // single vertex polygons
    queue_vertex(0, 0, 1'b1);
    queue_vertex(C_LO, C_HI, 1'b1);
    // 3-4-5 triangle both ways round
    queue_vertex(0, 0, 1'b0);
    queue_vertex(4, 0, 1'b0);
    queue_vertex(0, 3, 1'b1);
    queue_vertex(0, 3, 1'b0);
    queue_vertex(4, 0, 1'b0);
    queue_vertex(0, 0, 1'b1);
    // longest diagonal
    queue_vertex(C_LO, C_LO, 1'b0);
    queue_vertex(C_HI, C_HI, 1'b1);
    queue_square_loop(4, 1'b1);
    // zero length edges
    queue_vertex(-7, 9, 1'b0);
    queue_vertex(-7, 9, 1'b1);
    drain();

    // long polygons around the full square, both ways round
    queue_square_loop(40, 1'b1);
    queue_square_loop(41, 1'b0);
    drain();

    run_phase(0, 0);
    run_phase(82, 0);
    run_phase(0, 82);
    run_phase(37, 37);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (shape_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, shape_q.size());
    end
    $display("run covered %0d vertices and %0d polygons under four pacing mixes",
             vertices_taken, shapes_checked);
    $display("%0d polygons past the vertex limit, %0d with a saturated sum, %0d errors",
             ovf_shapes, clamped_shapes, errors);
    if (errors == 0) begin
      $display("PASS polygon_perimeter_area");
    end else begin
      $display("FAIL polygon_perimeter_area");
    end
    $finish;
  end

endmodule
